/* rtl/vca_pkg.sv */
// package: types, widths and codes of the voice channel allocator
`default_nettype none
package vca_pkg;

  localparam int CHANNELS_DEF = 32;
  localparam int IDX_W        = 6;
  localparam int ENT_W        = 10;
  localparam int SUB_W        = 3;
  localparam int TIME_W       = 32;
  localparam int ACT_W        = 6;
  localparam int REL_W        = 5;
  localparam int CHAN_W       = 5;
  localparam int ADDR_W       = 3;
  localparam int DATA_W       = 32;

  localparam logic       CMD_ALLOC   = 1'b0;
  localparam logic       CMD_RELEASE = 1'b1;
  localparam logic       REG_ACTIVE  = 1'b0;
  localparam logic       REG_PLAYER  = 1'b1;

  localparam logic [ACT_W-1:0] ACTIVE_RST = 6'd32;
  localparam logic [ENT_W-1:0] PLAYER_RST = 10'd1;

  // running candidate handed from cell to cell
  typedef struct packed {
    logic              done;
    logic              found;
    logic              busy;
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] oldest;
  } scan_t;

  // request fields broadcast to every cell
  typedef struct packed {
    logic [ENT_W-1:0] ent;
    logic [SUB_W-1:0] sub;
    logic [ENT_W-1:0] player;
    logic [ACT_W-1:0] active;
  } req_t;

  // update of one cell
  typedef struct packed {
    logic              en;
    logic              alloc;
    logic [IDX_W-1:0]  idx;
    logic              raw;
    logic [ENT_W-1:0]  ent;
    logic [SUB_W-1:0]  sub;
    logic [TIME_W-1:0] now;
  } wr_t;

endpackage
`default_nettype wire

/* rtl/vca_in_if.sv */
// interface: request channel of the voice channel allocator
`default_nettype none
interface vca_in_if;
  import vca_pkg::*;

  logic              valid;
  logic              ready;
  logic              cmd;
  logic [ENT_W-1:0]  entity;
  logic [SUB_W-1:0]  entity_channel;
  logic [TIME_W-1:0] now;
  logic              as_raw;
  logic [REL_W-1:0]  release_index;

  modport source (output valid, cmd, entity, entity_channel, now, as_raw, release_index,
                  input ready);
  modport sink   (input valid, cmd, entity, entity_channel, now, as_raw, release_index,
                  output ready);
endinterface
`default_nettype wire

/* rtl/vca_out_if.sv */
// interface: result channel of the voice channel allocator
`default_nettype none
interface vca_out_if;
  import vca_pkg::*;

  logic              valid;
  logic              ready;
  logic              granted;
  logic [CHAN_W-1:0] channel;
  logic              evicted;

  modport source (output valid, granted, channel, evicted, input ready);
  modport sink   (input valid, granted, channel, evicted, output ready);
endinterface
`default_nettype wire

/* rtl/vca_cell.sv */
// module: one channel cell, holding its state and passing the scan on
`default_nettype none
module vca_cell #(
  parameter int INDEX = 0
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire vca_pkg::req_t  req,
  input  wire vca_pkg::wr_t   wr,
  input  wire vca_pkg::scan_t scan_in,
  output vca_pkg::scan_t      scan_out
);
  import vca_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic              busy;
  logic              raw;
  logic [ENT_W-1:0]  owner;
  logic [SUB_W-1:0]  osub;
  logic [TIME_W-1:0] start;
  logic              in_range;
  logic              same_owner;
  logic              is_protected;
  scan_t             scan_next;

  assign in_range     = (7'(INDEX) < 7'(req.active));
  assign same_owner   = (req.sub != '0) && (owner == req.ent) && (osub == req.sub);
  assign is_protected = (owner == req.player) && (req.ent != req.player);

  always_comb begin
    scan_next = scan_in;
    if (!scan_in.done && in_range && !raw) begin
      if (!busy) begin
        scan_next.done  = 1'b1;
        scan_next.found = 1'b1;
        scan_next.busy  = 1'b0;
        scan_next.idx   = MY_IDX;
      end else if (same_owner) begin
        scan_next.done  = 1'b1;
        scan_next.found = 1'b1;
        scan_next.busy  = 1'b1;
        scan_next.idx   = MY_IDX;
      end else if (!is_protected && (start < scan_in.oldest)) begin
        scan_next.found  = 1'b1;
        scan_next.busy   = 1'b1;
        scan_next.idx    = MY_IDX;
        scan_next.oldest = start;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_out <= scan_next;
    if (rst) begin
      busy <= 1'b0;
      raw  <= 1'b0;
    end else if (wr.en && (wr.idx == MY_IDX)) begin
      busy <= wr.alloc;
      raw  <= wr.alloc & wr.raw;
    end
    if (wr.en && wr.alloc && (wr.idx == MY_IDX)) begin
      owner <= wr.ent;
      osub  <= wr.sub;
      start <= wr.now;
    end
  end

endmodule
`default_nettype wire

/* rtl/vca_ctrl.sv */
// module: request sequencer, scan timing, cell update and result register
`default_nettype none
module vca_ctrl #(
  parameter int CHANNELS = vca_pkg::CHANNELS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  vca_in_if.sink                         in_ch,
  vca_out_if.source                      out_ch,
  input  wire logic [vca_pkg::ACT_W-1:0] active,
  input  wire logic [vca_pkg::ENT_W-1:0] player,
  input  wire vca_pkg::scan_t            tail,
  output vca_pkg::scan_t                 seed,
  output vca_pkg::req_t                  req,
  output vca_pkg::wr_t                   wr
);
  import vca_pkg::*;

  typedef enum logic [1:0] {IDLE, SCAN, COMMIT} state_t;

  state_t            state;
  logic [IDX_W-1:0]  cnt;
  logic              cmd;
  logic [ENT_W-1:0]  ent;
  logic [SUB_W-1:0]  sub;
  logic [TIME_W-1:0] now;
  logic              raw;
  logic [REL_W-1:0]  rel;
  logic              res_valid;
  logic              res_granted;
  logic [CHAN_W-1:0] res_channel;
  logic              res_evicted;
  logic              in_fire;
  logic              commit;
  logic              rel_ok;
  logic              granted_next;
  logic [CHAN_W-1:0] channel_next;
  logic              evicted_next;

  assign in_ch.ready    = (state == IDLE);
  assign in_fire        = in_ch.valid && in_ch.ready;
  assign commit         = (state == COMMIT) && (!res_valid || out_ch.ready);
  assign rel_ok         = (7'(rel) < 7'(CHANNELS));

  assign out_ch.valid   = res_valid;
  assign out_ch.granted = res_granted;
  assign out_ch.channel = res_channel;
  assign out_ch.evicted = res_evicted;

  assign seed = '{done: 1'b0, found: 1'b0, busy: 1'b0, idx: '0, oldest: now};
  assign req  = '{ent: ent, sub: sub, player: player, active: active};

  always_comb begin
    wr.alloc = (cmd == CMD_ALLOC);
    wr.raw   = raw;
    wr.ent   = ent;
    wr.sub   = sub;
    wr.now   = now;
    if (cmd == CMD_RELEASE) begin
      wr.en        = commit && rel_ok;
      wr.idx       = IDX_W'(rel);
      granted_next = rel_ok;
      channel_next = rel_ok ? CHAN_W'(rel) : '0;
      evicted_next = 1'b0;
    end else begin
      wr.en        = commit && tail.found;
      wr.idx       = tail.idx;
      granted_next = tail.found;
      channel_next = tail.found ? tail.idx[CHAN_W-1:0] : '0;
      evicted_next = tail.found && tail.busy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (commit) begin
        res_valid <= 1'b1;
      end else if (out_ch.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          cnt <= '0;
          if (in_fire) begin
            state <= (in_ch.cmd == CMD_RELEASE) ? COMMIT : SCAN;
          end
        end
        SCAN: begin
          cnt <= cnt + 1'b1;
          if (cnt == IDX_W'(CHANNELS - 1)) begin
            state <= COMMIT;
          end
        end
        COMMIT: begin
          if (commit) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
    if (in_fire) begin
      cmd <= in_ch.cmd;
      ent <= in_ch.entity;
      sub <= in_ch.entity_channel;
      now <= in_ch.now;
      raw <= in_ch.as_raw;
      rel <= in_ch.release_index;
    end
    if (commit) begin
      res_granted <= granted_next;
      res_channel <= channel_next;
      res_evicted <= evicted_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/voice_channel_allocator.sv */
// top level: voice channel allocator with oldest-voice stealing
// requests arrive on in_ch, one result per request leaves on out_ch; both are
// valid/ready channels, a transfer taking place when valid and ready are high.
// an allocate request enters a row of CHANNELS cells, one per channel, and
// the running candidate moves one cell per cycle; the result is registered in
// the COMMIT state that follows the scan. a release needs no scan, goes
// straight to COMMIT and has its result registered there.
// one request is in work at a time: the next is taken only once the last one
// has been committed to the result register.
// the result register holds a finished result while out_ch is stalled; the
// next request is taken meanwhile, and its result waits for the register.
// registers on the apb port: active_channels at 0x0, player_entity at 0x4,
// written in the access phase, pready always high.
// reset clears all busy and raw flags, the result register and loads
// active_channels with 32 and player_entity with 1; no clearing pass.
`default_nettype none
module voice_channel_allocator #(
  parameter int CHANNELS = vca_pkg::CHANNELS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  vca_in_if.sink                          in_ch,
  vca_out_if.source                       out_ch,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [vca_pkg::ADDR_W-1:0] paddr,
  input  wire logic [vca_pkg::DATA_W-1:0] pwdata,
  output logic      [vca_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);
  import vca_pkg::*;

  logic [ACT_W-1:0] active_channels;
  logic [ENT_W-1:0] player_entity;
  scan_t            links [CHANNELS+1];
  req_t             req;
  wr_t              wr;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_channels <= ACTIVE_RST;
      player_entity   <= PLAYER_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_ACTIVE: active_channels <= pwdata[ACT_W-1:0];
        REG_PLAYER: player_entity   <= pwdata[ENT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ACTIVE: prdata = DATA_W'(active_channels);
      REG_PLAYER: prdata = DATA_W'(player_entity);
      default:    prdata = '0;
    endcase
  end

  vca_ctrl #(.CHANNELS(CHANNELS)) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .active (active_channels),
    .player (player_entity),
    .tail   (links[CHANNELS]),
    .seed   (links[0]),
    .req    (req),
    .wr     (wr)
  );

  for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
    vca_cell #(.INDEX(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .req      (req),
      .wr       (wr),
      .scan_in  (links[i]),
      .scan_out (links[i+1])
    );
  end

endmodule
`default_nettype wire

/* rtl/vca_checker.sv */
// checker: port-level properties of the voice channel allocator, and its bind
`default_nettype none
module vca_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_granted,
  input wire logic [vca_pkg::CHAN_W-1:0] out_channel,
  input wire logic out_evicted
);

  a_evict_granted: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_evicted || out_granted))
    else $error("evicted result without a grant");

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while another is in work");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_channel)
                                   && $stable(out_granted) && $stable(out_evicted)))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind voice_channel_allocator vca_checker u_vca_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_granted (out_ch.granted),
  .out_channel (out_ch.channel),
  .out_evicted (out_ch.evicted)
);
`default_nettype wire

/* verif/testbench.sv */
// testbench: directed and random transfers through the voice channel allocator
module testbench;

  localparam int NUM_CH       = vca_pkg::CHANNELS_DEF;
  localparam int DRAIN_CYCLES = NUM_CH + 8;
  localparam int PHASE_ITEMS  = 92;

  typedef struct packed {
    logic                       cmd;
    logic [vca_pkg::ENT_W-1:0]  entity;
    logic [vca_pkg::SUB_W-1:0]  entity_channel;
    logic [vca_pkg::TIME_W-1:0] now;
    logic                       as_raw;
    logic [vca_pkg::REL_W-1:0]  release_index;
  } voice_request_t;

  typedef struct packed {
    logic                       granted;
    logic [vca_pkg::CHAN_W-1:0] channel;
    logic                       evicted;
  } grant_t;

  class channel_scoreboard;
    bit                         busy      [NUM_CH];
    bit                         raw       [NUM_CH];
    logic [vca_pkg::ENT_W-1:0]  owner     [NUM_CH];
    logic [vca_pkg::SUB_W-1:0]  owner_sub [NUM_CH];
    logic [vca_pkg::TIME_W-1:0] started   [NUM_CH];
    logic [vca_pkg::ACT_W-1:0]  active_count;
    logic [vca_pkg::ENT_W-1:0]  player;
    grant_t                     pending [$];
    int                         errors;

    function new();
      active_count = vca_pkg::ACTIVE_RST;
      player       = vca_pkg::PLAYER_RST;
      errors       = 0;
      for (int i = 0; i < NUM_CH; i++) begin
        busy[i]      = 1'b0;
        raw[i]       = 1'b0;
        owner[i]     = '0;
        owner_sub[i] = '0;
        started[i]   = '0;
      end
    endfunction

    function void set_register(logic sel, logic [vca_pkg::DATA_W-1:0] value);
      if (sel == vca_pkg::REG_ACTIVE) begin
        active_count = value[vca_pkg::ACT_W-1:0];
      end else begin
        player = value[vca_pkg::ENT_W-1:0];
      end
    endfunction

    // works out the grant for one request and updates the channel table
    function void note_request(voice_request_t r);
      grant_t                     g;
      int                         limit;
      int                         pick;
      logic [vca_pkg::TIME_W-1:0] oldest;
      g = '0;
      if (r.cmd == vca_pkg::CMD_RELEASE) begin
        busy[r.release_index] = 1'b0;
        raw[r.release_index]  = 1'b0;
        g.granted = 1'b1;
        g.channel = r.release_index;
      end else begin
        limit  = (active_count < NUM_CH) ? int'(active_count) : NUM_CH;
        oldest = r.now;
        pick   = -1;
        for (int i = 0; i < limit; i++) begin
          if (raw[i]) continue;
          if (!busy[i]) begin
            pick = i;
            break;
          end
          if (r.entity_channel != '0 && owner[i] == r.entity &&
              owner_sub[i] == r.entity_channel) begin
            pick = i;
            break;
          end
          if (!(owner[i] == player && r.entity != player) && started[i] < oldest) begin
            oldest = started[i];
            pick   = i;
          end
        end
        if (pick >= 0) begin
          g.granted       = 1'b1;
          g.channel       = pick[vca_pkg::CHAN_W-1:0];
          g.evicted       = busy[pick];
          busy[pick]      = 1'b1;
          raw[pick]       = r.as_raw;
          owner[pick]     = r.entity;
          owner_sub[pick] = r.entity_channel;
          started[pick]   = r.now;
        end
      end
      pending.push_back(g);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(grant_t got);
      grant_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result granted=%0d channel=%0d evicted=%0d",
                         got.granted, got.channel, got.evicted));
      end else begin
        want = pending.pop_front();
        if (got.granted !== want.granted || got.channel !== want.channel ||
            got.evicted !== want.evicted) begin
          report($sformatf("got granted=%0d channel=%0d evicted=%0d, want %0d/%0d/%0d",
                           got.granted, got.channel, got.evicted,
                           want.granted, want.channel, want.evicted));
        end
      end
    endtask
  endclass

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [vca_pkg::ADDR_W-1:0]   paddr;
  logic [vca_pkg::DATA_W-1:0]   pwdata;
  logic [vca_pkg::DATA_W-1:0]   prdata;
  logic                         pready;
  logic                         no_idle;
  logic [vca_pkg::TIME_W-1:0]   clock_ms;
  channel_scoreboard            sb;

  vca_in_if  in_ch ();
  vca_out_if out_ch ();

  voice_channel_allocator u_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk = ~clk;

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic voice_request_t alloc_req(logic [vca_pkg::ENT_W-1:0] ent,
                                               logic [vca_pkg::SUB_W-1:0] sub,
                                               logic [vca_pkg::TIME_W-1:0] t,
                                               logic as_raw);
    voice_request_t r;
    r                = '0;
    r.cmd            = vca_pkg::CMD_ALLOC;
    r.entity         = ent;
    r.entity_channel = sub;
    r.now            = t;
    r.as_raw         = as_raw;
    return r;
  endfunction

  function automatic voice_request_t release_req(logic [vca_pkg::REL_W-1:0] idx);
    voice_request_t r;
    r               = '0;
    r.cmd           = vca_pkg::CMD_RELEASE;
    r.release_index = idx;
    return r;
  endfunction

  // well-formed traffic: mostly a small set of entities, a running clock, some odd times
  function automatic voice_request_t random_request();
    voice_request_t r;
    int             lim;
    lim = (sb.active_count < NUM_CH) ? int'(sb.active_count) : NUM_CH;
    if (lim < 1) lim = 1;
    r.cmd = ($urandom_range(0, 99) < 30) ? vca_pkg::CMD_RELEASE : vca_pkg::CMD_ALLOC;
    case ($urandom_range(0, 6))
      0:       r.entity = sb.player;
      1:       r.entity = 10'd5;
      2:       r.entity = 10'd77;
      3:       r.entity = 10'd1022;
      4:       r.entity = 10'($urandom_range(0, 1023));
      5:       r.entity = $urandom_range(0, 1) ? '0 : '1;
      default: r.entity = sb.player;
    endcase
    r.entity_channel = 3'($urandom_range(0, 7));
    clock_ms += $urandom_range(0, 40);
    case ($urandom_range(0, 19))
      0:       r.now = $urandom();
      1:       r.now = clock_ms - $urandom_range(0, 200);
      default: r.now = clock_ms;
    endcase
    r.as_raw = ($urandom_range(0, 9) == 0);
    r.release_index = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                   : 5'($urandom_range(0, lim - 1));
    return r;
  endfunction

  task automatic send_request(voice_request_t r);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.cmd            <= r.cmd;
    in_ch.entity         <= r.entity;
    in_ch.entity_channel <= r.entity_channel;
    in_ch.now            <= r.now;
    in_ch.as_raw         <= r.as_raw;
    in_ch.release_index  <= r.release_index;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  task automatic apb_write(logic sel, logic [vca_pkg::DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(sel, value);
  endtask

  // transfer monitor on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_request('{in_ch.cmd, in_ch.entity, in_ch.entity_channel, in_ch.now,
                          in_ch.as_raw, in_ch.release_index});
      end
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result('{out_ch.granted, out_ch.channel, out_ch.evicted});
      end
    end
  end

  // result side back-pressure
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!out_ch.valid) @(posedge clk);
        repeat (stall - 1) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  initial begin
    #(12 * 800000);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    sb = new();
    no_idle  = 1'b0;
    clock_ms = '0;
    rst                  <= 1'b1;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.cmd            <= vca_pkg::CMD_ALLOC;
    in_ch.entity         <= '0;
    in_ch.entity_channel <= '0;
    in_ch.now            <= '0;
    in_ch.as_raw         <= 1'b0;
    in_ch.release_index  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: raw stream, player sound, release of a raw and a free channel
    send_request(alloc_req(10'd1023, 3'd7, 32'hFFFF_FFFF, 1'b1));
    send_request(alloc_req(10'd1, 3'd0, 32'd0, 1'b0));
    send_request(release_req(5'd0));
    send_request(release_req(5'd31));
    wait_drain();

    // four channels: same-entity reuse, refusal, oldest steal, player protection
    apb_write(vca_pkg::REG_ACTIVE, 32'd4);
    apb_write(vca_pkg::REG_PLAYER, 32'd1023);
    send_request(alloc_req(10'd1023, 3'd7, 32'd100, 1'b0));
    send_request(alloc_req(10'd5, 3'd1, 32'd50, 1'b1));
    send_request(alloc_req(10'd5, 3'd1, 32'd200, 1'b0));
    send_request(alloc_req(10'd5, 3'd1, 32'd300, 1'b0));
    send_request(alloc_req(10'd9, 3'd0, 32'd0, 1'b0));
    send_request(alloc_req(10'd9, 3'd0, 32'hFFFF_FFFF, 1'b0));
    send_request(alloc_req(10'd1023, 3'd0, 32'hFFFF_FFFF, 1'b0));
    send_request(alloc_req(10'd9, 3'd0, 32'hFFFF_FFFF, 1'b0));
    send_request(release_req(5'd2));
    send_request(release_req(5'd31));
    wait_drain();

    // empty scan
    apb_write(vca_pkg::REG_ACTIVE, 32'd0);
    send_request(alloc_req(10'd9, 3'd3, 32'd1000, 1'b0));
    send_request(release_req(5'd1));
    wait_drain();

    // count past the table saturates
    apb_write(vca_pkg::REG_ACTIVE, 32'd63);
    apb_write(vca_pkg::REG_PLAYER, 32'd0);
    send_request(alloc_req(10'd0, 3'd5, 32'd10, 1'b0));
    send_request(alloc_req(10'd700, 3'd2, 32'd10, 1'b1));
    send_request(alloc_req(10'd341, 3'd4, 32'h5555_5555, 1'b0));

    for (int phase = 0; phase < 6; phase++) begin
      wait_drain();
      case (phase)
        0: begin
          apb_write(vca_pkg::REG_ACTIVE, 32'd32);
          apb_write(vca_pkg::REG_PLAYER, 32'd1);
          clock_ms = '0;
        end
        1: begin
          apb_write(vca_pkg::REG_ACTIVE, 32'd1);
          apb_write(vca_pkg::REG_PLAYER, $urandom_range(0, 1023));
        end
        2: begin
          apb_write(vca_pkg::REG_ACTIVE, 32'd8);
          apb_write(vca_pkg::REG_PLAYER, 32'd0);
        end
        3: begin
          apb_write(vca_pkg::REG_ACTIVE, $urandom_range(1, 32));
          apb_write(vca_pkg::REG_PLAYER, 32'd1023);
          clock_ms = 32'hFFFF_F000;
        end
        4: begin
          apb_write(vca_pkg::REG_ACTIVE, 32'd63);
          apb_write(vca_pkg::REG_PLAYER, $urandom_range(0, 1023));
        end
        default: begin
          apb_write(vca_pkg::REG_ACTIVE, $urandom_range(2, 16));
          apb_write(vca_pkg::REG_PLAYER, 32'd5);
        end
      endcase
      no_idle = (phase == 2 || phase == 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_request(random_request());
      end
    end

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending.size() != 0) sb.report("expected results left over");
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* voice_channel_allocator.f */
rtl/vca_pkg.sv
rtl/vca_in_if.sv
rtl/vca_out_if.sv
rtl/vca_cell.sv
rtl/vca_ctrl.sv
rtl/voice_channel_allocator.sv
rtl/vca_checker.sv
verif/testbench.sv
